// ===== src/assert_macros.svh =====
// Assertion macros included by stepper_coil_position_tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sct_pkg.sv =====
// Types, constants and pattern tables for the stepper coil position tracker.
package sct_pkg;

  localparam int unsigned AngleW = 12;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned StepW  = 7;
  localparam int unsigned CoilW  = 4;

  localparam logic [AngleW-1:0] AngleFull  = AngleW'(3600);
  localparam logic [PhaseW-1:0] PhaseReset = PhaseW'(3);

  localparam logic signed [StepW-1:0] StepNone     = StepW'(0);
  localparam logic signed [StepW-1:0] StepHalfFwd  = StepW'(18);
  localparam logic signed [StepW-1:0] StepFullFwd  = StepW'(36);
  localparam logic signed [StepW-1:0] StepHalfBack = -StepW'(18);
  localparam logic signed [StepW-1:0] StepFullBack = -StepW'(36);

  typedef logic [AngleW-1:0]        angle_t;
  typedef logic [PhaseW-1:0]        phase_t;
  typedef logic signed [StepW-1:0]  step_t;
  typedef logic [CoilW-1:0]         coil_t;

  typedef struct packed {
    logic   hit;
    phase_t phase;
    step_t  step;
  } move_t;

  function automatic coil_t uni_pattern(input phase_t idx);
    coil_t pat;
    unique case (idx)
      3'd0: pat = 4'd1;
      3'd1: pat = 4'd3;
      3'd2: pat = 4'd2;
      3'd3: pat = 4'd6;
      3'd4: pat = 4'd4;
      3'd5: pat = 4'd12;
      3'd6: pat = 4'd8;
      3'd7: pat = 4'd9;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

  function automatic coil_t bi_pattern(input logic [1:0] idx);
    coil_t pat;
    unique case (idx)
      2'd0: pat = 4'd10;
      2'd1: pat = 4'd6;
      2'd2: pat = 4'd5;
      2'd3: pat = 4'd9;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

// ===== src/sct_in_if.sv =====
// Input channel: coil pattern and coil valid flag.
interface sct_in_if;
  import sct_pkg::*;

  logic  valid;
  logic  ready;
  coil_t coil_bits;
  logic  coils_valid;

  modport source (output valid, output coil_bits, output coils_valid, input ready);
  modport sink   (input valid, input coil_bits, input coils_valid, output ready);
endinterface

// ===== src/sct_out_if.sv =====
// Result channel: angle, phase and step of one item.
interface sct_out_if;
  import sct_pkg::*;

  logic   valid;
  logic   ready;
  angle_t angle_tenths;
  phase_t phase_index;
  step_t  step_tenths;

  modport source (output valid, output angle_tenths, output phase_index,
                  output step_tenths, input ready);
  modport sink   (input valid, input angle_tenths, input phase_index,
                  input step_tenths, output ready);
endinterface

// ===== src/stepper_coil_position_tracker.sv =====
// Stepper coil position tracker top level.
//
//   channel  | dir | payload                                  | handshake
//   in_ch    | in  | coil_bits[3:0], coils_valid              | valid/ready
//   out_ch   | out | angle_tenths[11:0], phase_index[2:0],    | valid/ready
//            |     | step_tenths[6:0] signed                  |
//   cfg      | in  | cfg_wr_data (unipolar_mode)              | cfg_wr_en
//
// One item per cycle while in_ch.ready is high; the result appears in
// the cycle after its transfer. The pattern match and the wrapped angle
// add feed the state registers, which also drive out_ch. in_ch.ready
// stays high while the result register is empty or being drained.
// Synchronous reset: phase 3, angle 0, unipolar mode, no result pending.
`include "assert_macros.svh"

module stepper_coil_position_tracker (
  input  logic clk,
  input  logic rst_n,
  sct_in_if.sink    in_ch,
  sct_out_if.source out_ch,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data
);
  import sct_pkg::*;

  logic   mode_r;
  phase_t phase_r, phase_nxt;
  angle_t angle_r, angle_nxt;
  step_t  step_r;
  logic   out_valid_r;
  logic   in_fire;
  move_t  move;
  logic signed [AngleW:0] sum;

  sct_step_decode u_decode (
    .coil_bits     (in_ch.coil_bits),
    .coils_valid   (in_ch.coils_valid),
    .unipolar_mode (mode_r),
    .phase         (phase_r),
    .move          (move)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign sum = $signed({1'b0, angle_r}) + (AngleW+1)'(move.step);

  always_comb begin
    phase_nxt = phase_r;
    angle_nxt = angle_r;
    if (move.hit) begin
      phase_nxt = move.phase;
      priority if (sum < 0) begin
        angle_nxt = AngleW'(sum + $signed({1'b0, AngleFull}));
      end else if (sum >= $signed({1'b0, AngleFull})) begin
        angle_nxt = AngleW'(sum - $signed({1'b0, AngleFull}));
      end else begin
        angle_nxt = AngleW'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b1;
      phase_r     <= PhaseReset;
      angle_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        angle_r     <= angle_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      step_r <= move.step;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.angle_tenths = angle_r;
  assign out_ch.phase_index  = phase_r;
  assign out_ch.step_tenths  = step_r;

  `ASSERT_IMPL(a_angle_range, 1'b1, angle_r < AngleFull, "angle out of range")
  `ASSERT_NEXT(a_bipolar_phase, in_fire && !mode_r && move.hit, phase_r[2] == 1'b0, "bipolar phase above 3")
  `ASSERT_NEXT(a_miss_holds, in_fire && !move.hit, $stable(angle_r) && $stable(phase_r) && step_r == StepNone, "unmatched item moved state")
endmodule

// ===== src/sct_step_decode.sv =====
// Neighbor pattern match: finds the phase move for one coil pattern.
module sct_step_decode (
  input  sct_pkg::coil_t  coil_bits,
  input  logic            coils_valid,
  input  logic            unipolar_mode,
  input  sct_pkg::phase_t phase,
  output sct_pkg::move_t  move
);
  import sct_pkg::*;

  phase_t     um1, um2, up2, up1;
  logic [1:0] bm1, bp1;

  assign um1 = phase - PhaseW'(1);
  assign um2 = phase - PhaseW'(2);
  assign up2 = phase + PhaseW'(2);
  assign up1 = phase + PhaseW'(1);
  assign bm1 = phase[1:0] - 2'd1;
  assign bp1 = phase[1:0] + 2'd1;

  always_comb begin
    move = '{hit: 1'b0, phase: phase, step: StepNone};
    if (coils_valid) begin
      if (unipolar_mode) begin
        priority if (uni_pattern(um1) == coil_bits) begin
          move = '{hit: 1'b1, phase: um1, step: StepHalfBack};
        end else if (uni_pattern(um2) == coil_bits) begin
          move = '{hit: 1'b1, phase: um2, step: StepFullBack};
        end else if (uni_pattern(up2) == coil_bits) begin
          move = '{hit: 1'b1, phase: up2, step: StepFullFwd};
        end else if (uni_pattern(up1) == coil_bits) begin
          move = '{hit: 1'b1, phase: up1, step: StepHalfFwd};
        end
      end else begin
        priority if (bi_pattern(bm1) == coil_bits) begin
          move = '{hit: 1'b1, phase: {1'b0, bm1}, step: StepFullBack};
        end else if (bi_pattern(bp1) == coil_bits) begin
          move = '{hit: 1'b1, phase: {1'b0, bp1}, step: StepFullFwd};
        end
      end
    end
  end
endmodule
